[rtl/rgbhsv_pkg.sv]
`timescale 1ns / 1ps

package rgbhsv_pkg;

   localparam int CHAN_W     = 8;
   localparam int HUE_OUT_W  = 16;
   localparam int SAT_W      = 16;
   localparam int SAT_BITS   = 16;
   localparam int HUE_DIV_W  = 11;
   localparam int HUE_SEXT_W = HUE_DIV_W + 1;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

[rtl/rgbhsv_req_if.sv]
`timescale 1ns / 1ps

interface rgbhsv_req_if;
   import rgbhsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);

endinterface

[rtl/rgbhsv_rsp_if.sv]
`timescale 1ns / 1ps

interface rgbhsv_rsp_if;
   import rgbhsv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [HUE_OUT_W-1:0] hue_out;
   logic [SAT_W-1:0]     saturation_out;
   logic [CHAN_W-1:0]    value_out;

   modport source (output valid, output hue_out, output saturation_out, output value_out,
                   input ready);
   modport sink   (input valid, input hue_out, input saturation_out, input value_out,
                   output ready);

endinterface

[rtl/rgb_to_hsv_converter_core.sv]
`timescale 1ns / 1ps

// RGB to HSV converter. One pixel transaction enters per clock unless the
// pipeline is full and its result stalls: a front stage finds max, min,
// range and the hue sector, then a chain of long-division stages produces
// one saturation bit and one hue bit per stage, so the wider quotient
// sets the depth. Every stage holds a valid bit and empty stages are filled
// while the output waits, so a stalled result does not stop new pixels until
// the pipeline is full. Value is the largest channel, saturation is
// floor(32768*range/max) and hue is the low 16 bits of a HUE_BITS-bit turn
// fraction; black and grey pixels give zero hue.
module rgb_to_hsv_converter_core #(
   parameter int HUE_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   rgbhsv_req_if.sink    req_ch,
   rgbhsv_rsp_if.source  rsp_ch
);
   import rgbhsv_pkg::*;

   localparam int NSTG = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

   logic [NSTG:0]          valid_ff;
   logic [NSTG+1:0]        rdy;
   logic [CHAN_W-1:0]      mx_ff   [NSTG+1];
   logic [CHAN_W-1:0]      mx_in   [NSTG+1];
   logic [CHAN_W-1:0]      srem_ff [NSTG+1];
   logic [CHAN_W-1:0]      srem_in [NSTG+1];
   logic [SAT_W-1:0]       squo_ff [NSTG+1];
   logic [SAT_W-1:0]       squo_in [NSTG+1];
   logic [HUE_DIV_W-1:0]   hrem_ff [NSTG+1];
   logic [HUE_DIV_W-1:0]   hrem_in [NSTG+1];
   logic [HUE_DIV_W-1:0]   hdiv_ff [NSTG+1];
   logic [HUE_DIV_W-1:0]   hdiv_in [NSTG+1];
   logic [HUE_BITS-1:0]    hquo_ff [NSTG+1];
   logic [HUE_BITS-1:0]    hquo_in [NSTG+1];
   logic [NSTG:0]          hz_ff;
   logic [NSTG:0]          hz_in;

   logic [CHAN_W-1:0]      r;
   logic [CHAN_W-1:0]      g;
   logic [CHAN_W-1:0]      b;
   logic [CHAN_W-1:0]      mx;
   logic [CHAN_W-1:0]      mn;
   logic [CHAN_W-1:0]      rng;
   logic [HUE_DIV_W-1:0]   rng_w;
   logic [HUE_DIV_W-1:0]   num;
   sector_type             sector;
   logic [HUE_OUT_W-1:0]   hue_fit;

   // front stage: extremes, range and hue numerator
   always_comb begin
      r = req_ch.red_in;
      g = req_ch.green_in;
      b = req_ch.blue_in;
      if (r >= g && r >= b) begin
         sector = SECTOR_RED;
      end else if (g >= b) begin
         sector = SECTOR_GREEN;
      end else begin
         sector = SECTOR_BLUE;
      end
      mx = (r > g) ? r : g;
      mx = (b > mx) ? b : mx;
      mn = (r < g) ? r : g;
      mn = (b < mn) ? b : mn;
      rng   = mx - mn;
      rng_w = {{(HUE_DIV_W-CHAN_W){1'b0}}, rng};
      case (sector)
         SECTOR_RED: begin
            if (g >= b) begin
               num = {{(HUE_DIV_W-CHAN_W){1'b0}}, g - b};
            end else begin
               num = (rng_w << 2) + (rng_w << 1)
                     - {{(HUE_DIV_W-CHAN_W){1'b0}}, b - g};
            end
         end
         SECTOR_GREEN: begin
            num = (rng_w << 1) + {{(HUE_DIV_W-CHAN_W){1'b0}}, b}
                  - {{(HUE_DIV_W-CHAN_W){1'b0}}, r};
         end
         default: begin
            num = (rng_w << 2) + {{(HUE_DIV_W-CHAN_W){1'b0}}, r}
                  - {{(HUE_DIV_W-CHAN_W){1'b0}}, g};
         end
      endcase
   end

   // division stages, one quotient bit of each divide per stage
   always_comb begin
      logic [CHAN_W:0]       sshift;
      logic                  sbit;
      logic [HUE_SEXT_W-1:0] hshift;
      logic                  hbit;
      mx_in[0]   = mx;
      srem_in[0] = rng;
      squo_in[0] = '0;
      hrem_in[0] = num;
      hdiv_in[0] = (rng_w << 2) + (rng_w << 1);
      hquo_in[0] = '0;
      hz_in[0]   = (rng == '0);
      for (int k = 1; k <= NSTG; k++) begin
         mx_in[k]   = mx_ff[k-1];
         hdiv_in[k] = hdiv_ff[k-1];
         hz_in[k]   = hz_ff[k-1];
         srem_in[k] = srem_ff[k-1];
         squo_in[k] = squo_ff[k-1];
         hrem_in[k] = hrem_ff[k-1];
         hquo_in[k] = hquo_ff[k-1];
         if (k == 1) begin
            sshift = {1'b0, srem_ff[k-1]};
         end else begin
            sshift = {srem_ff[k-1], 1'b0};
         end
         sbit   = (sshift >= {1'b0, mx_ff[k-1]});
         hshift = {hrem_ff[k-1], 1'b0};
         hbit   = (hshift >= {1'b0, hdiv_ff[k-1]});
         if (k <= SAT_BITS) begin
            srem_in[k] = sbit ? CHAN_W'(sshift - {1'b0, mx_ff[k-1]}) : CHAN_W'(sshift);
            squo_in[k] = {squo_ff[k-1][SAT_W-2:0], sbit};
         end
         if (k <= HUE_BITS) begin
            hrem_in[k] = hbit ? HUE_DIV_W'(hshift - {1'b0, hdiv_ff[k-1]})
                              : HUE_DIV_W'(hshift);
            hquo_in[k] = {hquo_ff[k-1][HUE_BITS-2:0], hbit};
         end
      end
   end

   // a stage loads when it is empty or its transaction moves on
   always_comb begin
      rdy[NSTG+1] = rsp_ch.ready;
      for (int k = NSTG; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req_ch.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k <= NSTG; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NSTG; k++) begin
         if (rdy[k]) begin
            mx_ff[k]   <= mx_in[k];
            srem_ff[k] <= srem_in[k];
            squo_ff[k] <= squo_in[k];
            hrem_ff[k] <= hrem_in[k];
            hdiv_ff[k] <= hdiv_in[k];
            hquo_ff[k] <= hquo_in[k];
            hz_ff[k]   <= hz_in[k];
         end
      end
   end

   generate
      if (HUE_BITS >= HUE_OUT_W) begin : g_hue_trunc
         assign hue_fit = hquo_ff[NSTG][HUE_OUT_W-1:0];
      end else begin : g_hue_ext
         assign hue_fit = {{(HUE_OUT_W-HUE_BITS){1'b0}}, hquo_ff[NSTG]};
      end
   endgenerate

   assign rsp_ch.valid          = valid_ff[NSTG];
   assign rsp_ch.value_out      = mx_ff[NSTG];
   assign rsp_ch.saturation_out = (mx_ff[NSTG] == '0) ? '0 : squo_ff[NSTG];
   assign rsp_ch.hue_out        = hz_ff[NSTG] ? '0 : hue_fit;

   a_black_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.value_out == '0
      |-> rsp_ch.saturation_out == '0 && rsp_ch.hue_out == '0)
      else $error("black pixel gave nonzero hue or saturation");

   a_sat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.saturation_out <= SAT_W'(32768))
      else $error("saturation above one");

   a_grey_hue : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturation_out == '0 |-> rsp_ch.hue_out == '0)
      else $error("grey pixel gave nonzero hue");

   a_enter : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_ff[0])
      else $error("accepted transaction not held in front stage");

endmodule
